### rtl/core/qbve_pkg.sv
// types and constants shared by the quad batch vertex expander
`default_nettype none

package qbve_pkg;

  localparam int SLOT_W = 5;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_BEGIN  = 2'd2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic [16:0] ONE_FX  = 17'd65536;
  localparam logic [17:0] UV_MAX  = 18'd131072;
  localparam logic [15:0] IDX_MAX = 16'd16383;

  typedef struct packed {
    logic       load;
    logic       clr_cnt;
    logic       resolve;
    logic       emit;
    logic [1:0] kind;
    logic [1:0] corner;
    logic       last;
    logic       inc_quad;
  } qbve_cmd_t;

  typedef struct packed {
    logic tex_zero;
    logic hit;
    logic flush_due;
    logic out_free;
  } qbve_stat_t;

endpackage

`default_nettype wire

### rtl/core/qbve_if.sv
// item channels of the quad batch vertex expander
`default_nettype none

interface qbve_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [14:0]        rect_width;
  logic [14:0]        rect_height;
  logic [31:0]        texture_id;
  logic [16:0]        tex_left;
  logic [16:0]        tex_top;
  logic [16:0]        tex_span_x;
  logic [16:0]        tex_span_y;
  logic [23:0]        colour_in;

  modport source (
    output valid, operation, rect_x, rect_y, rect_width, rect_height, texture_id,
    output tex_left, tex_top, tex_span_x, tex_span_y, colour_in,
    input  ready
  );
  modport sink (
    input  valid, operation, rect_x, rect_y, rect_width, rect_height, texture_id,
    input  tex_left, tex_top, tex_span_x, tex_span_y, colour_in,
    output ready
  );
endinterface

interface qbve_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [16:0] vertex_x;
  logic signed [16:0] vertex_y;
  logic [17:0]        tex_u;
  logic [17:0]        tex_v;
  logic [23:0]        colour_out;
  logic [4:0]         slot_number;
  logic [31:0]        bound_texture;
  logic [13:0]        index_count;
  logic               last;

  modport source (
    output valid, result_kind, vertex_x, vertex_y, tex_u, tex_v, colour_out,
    output slot_number, bound_texture, index_count, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, vertex_x, vertex_y, tex_u, tex_v, colour_out,
    input  slot_number, bound_texture, index_count, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/qbve_ctrl.sv
// sequencing state machine of the quad batch vertex expander
`default_nettype none

module qbve_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  input  qbve_pkg::qbve_stat_t st,
  output qbve_pkg::qbve_cmd_t  cmd
);
  import qbve_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESOLVE = 3'd1;
  localparam logic [2:0] S_BIND    = 3'd2;
  localparam logic [2:0] S_VERT0   = 3'd3;
  localparam logic [2:0] S_VERT1   = 3'd4;
  localparam logic [2:0] S_VERT2   = 3'd5;
  localparam logic [2:0] S_VERT3   = 3'd6;
  localparam logic [2:0] S_FLUSH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_SUBMIT: state_next = S_RESOLVE;
            OP_END:    state_next = S_FLUSH;
            OP_BEGIN:  cmd.clr_cnt = 1'b1;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = (st.tex_zero || st.hit) ? S_VERT0 : S_BIND;
      end
      S_BIND: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_BIND;
          state_next = S_VERT0;
        end
      end
      S_VERT0: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_VERTEX;
          cmd.corner = CORNER_TL;
          state_next = S_VERT1;
        end
      end
      S_VERT1: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_VERTEX;
          cmd.corner = CORNER_TR;
          state_next = S_VERT2;
        end
      end
      S_VERT2: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_VERTEX;
          cmd.corner = CORNER_BR;
          state_next = S_VERT3;
        end
      end
      S_VERT3: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_VERTEX;
          cmd.corner   = CORNER_BL;
          cmd.inc_quad = 1'b1;
          cmd.last     = !st.flush_due;
          state_next   = st.flush_due ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_FLUSH;
          cmd.last    = 1'b1;
          cmd.clr_cnt = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/qbve_dpath.sv
// slot table, batch counters, corner arithmetic and result register
`default_nettype none

module qbve_dpath #(
  parameter int MAX_QUADS  = 2048,
  parameter int SLOT_COUNT = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qbve_pkg::qbve_cmd_t  cmd,
  output qbve_pkg::qbve_stat_t st,
  input  logic signed [15:0]   rect_x,
  input  logic signed [15:0]   rect_y,
  input  logic [14:0]          rect_width,
  input  logic [14:0]          rect_height,
  input  logic [31:0]          texture_id,
  input  logic [16:0]          tex_left,
  input  logic [16:0]          tex_top,
  input  logic [16:0]          tex_span_x,
  input  logic [16:0]          tex_span_y,
  input  logic [23:0]          colour_in,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           result_kind,
  output logic signed [16:0]   vertex_x,
  output logic signed [16:0]   vertex_y,
  output logic [17:0]          tex_u,
  output logic [17:0]          tex_v,
  output logic [23:0]          colour_out,
  output logic [4:0]           slot_number,
  output logic [31:0]          bound_texture,
  output logic [13:0]          index_count,
  output logic                 last
);
  import qbve_pkg::*;

  localparam int QW     = $clog2(MAX_QUADS + 1);
  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic signed [15:0] quad_x;
  logic signed [15:0] quad_y;
  logic [14:0]        quad_w;
  logic [14:0]        quad_h;
  logic [31:0]        quad_tex;
  logic [16:0]        org_u;
  logic [16:0]        org_v;
  logic [16:0]        span_u;
  logic [16:0]        span_v;
  logic [23:0]        quad_col;
  logic [SLOT_W-1:0]  cur_slot;

  logic [31:0]           slot_table [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] hit_next;
  logic [SLOT_W-1:0]     hit_idx;
  logic [SLOT_W-1:0]     slots_used;
  logic [QW-1:0]         quads_held;

  logic               tex_zero;
  logic               miss;
  logic               slot_room;
  logic               full_rect;
  logic [QW:0]        quads_inc;
  logic [15:0]        quads_wide;
  logic [15:0]        idx_raw;
  logic [15:0]        idx_sat;
  logic               right;
  logic               bottom;
  logic signed [16:0] x_sum;
  logic signed [16:0] y_sum;
  logic [17:0]        u_sum;
  logic [17:0]        v_sum;
  logic [17:0]        u_sat;
  logic [17:0]        v_sat;
  logic               is_vertex;
  logic               is_bind;
  logic               is_flush;

  // lookup against the live part of the table
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_next[i] = (slot_table[i] == texture_id) && (SLOT_W'(i) < slots_used);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign tex_zero  = (quad_tex == 32'd0);
  assign miss      = !tex_zero && !(|hit_vec);
  assign slot_room = (slots_used < SLOT_W'(SLOT_COUNT));
  assign full_rect = (tex_span_x == 17'd0) || (tex_span_y == 17'd0);

  assign quads_inc = (QW + 1)'(quads_held) + (QW + 1)'(1);

  assign st.tex_zero  = tex_zero;
  assign st.hit       = |hit_vec;
  assign st.flush_due = (quads_inc >= (QW + 1)'(MAX_QUADS)) ||
                        (slots_used >= SLOT_W'(SLOT_COUNT));
  assign st.out_free  = !out_valid || out_ready;

  // six indices per quad, saturated
  assign quads_wide = 16'(quads_held);
  assign idx_raw    = (quads_wide << 2) + (quads_wide << 1);
  assign idx_sat    = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;

  // corner selection
  assign right  = (cmd.corner == CORNER_TR) || (cmd.corner == CORNER_BR);
  assign bottom = (cmd.corner == CORNER_BR) || (cmd.corner == CORNER_BL);

  assign x_sum = {quad_x[15], quad_x} + (right ? {2'b00, quad_w} : 17'sd0);
  assign y_sum = {quad_y[15], quad_y} + (bottom ? {2'b00, quad_h} : 17'sd0);
  assign u_sum = {1'b0, org_u} + (right ? {1'b0, span_u} : 18'd0);
  assign v_sum = {1'b0, org_v} + (bottom ? {1'b0, span_v} : 18'd0);
  assign u_sat = (u_sum > UV_MAX) ? UV_MAX : u_sum;
  assign v_sat = (v_sum > UV_MAX) ? UV_MAX : v_sum;

  assign is_vertex = (cmd.kind == KIND_VERTEX);
  assign is_bind   = (cmd.kind == KIND_BIND);
  assign is_flush  = (cmd.kind == KIND_FLUSH);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quad_x   <= rect_x;
      quad_y   <= rect_y;
      quad_w   <= rect_width;
      quad_h   <= rect_height;
      quad_tex <= texture_id;
      quad_col <= colour_in;
      hit_vec  <= hit_next;
      org_u    <= full_rect ? 17'd0 : tex_left;
      org_v    <= full_rect ? 17'd0 : tex_top;
      span_u   <= full_rect ? ONE_FX : tex_span_x;
      span_v   <= full_rect ? ONE_FX : tex_span_y;
    end
    if (cmd.resolve) begin
      if (tex_zero) begin
        cur_slot <= '0;
      end else if (!miss) begin
        cur_slot <= hit_idx + SLOT_W'(1);
      end else if (slot_room) begin
        cur_slot <= slots_used + SLOT_W'(1);
      end else begin
        cur_slot <= slots_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && miss && slot_room) begin
      slot_table[slots_used[SIDX_W-1:0]] <= quad_tex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      quads_held <= '0;
    end else if (cmd.clr_cnt) begin
      slots_used <= '0;
      quads_held <= '0;
    end else begin
      if (cmd.resolve && miss && slot_room) begin
        slots_used <= slots_used + SLOT_W'(1);
      end
      if (cmd.inc_quad) begin
        quads_held <= quads_inc[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // fields outside the result kind read as zero
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_kind   <= cmd.kind;
      last          <= cmd.last;
      vertex_x      <= is_vertex ? x_sum : 17'sd0;
      vertex_y      <= is_vertex ? y_sum : 17'sd0;
      tex_u         <= is_vertex ? u_sat : 18'd0;
      tex_v         <= is_vertex ? v_sat : 18'd0;
      colour_out    <= is_vertex ? quad_col : 24'd0;
      slot_number   <= (is_vertex || is_bind) ? cur_slot : 5'd0;
      bound_texture <= is_bind ? quad_tex : 32'd0;
      index_count   <= is_flush ? idx_sat[13:0] : 14'd0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/quad_batch_vertex_expander_unit.sv
// top level of the quad batch vertex expander
//
// items: one item per operation. a submit item carries a screen rectangle,
// a texture id, a texture sub-rectangle and a colour. end batch flushes,
// begin batch clears the batch silently.
// results: one item per cycle at most, through a single output register.
// a submit gives an optional bind item, four corner vertices and an
// optional flush item; last marks the final result of a submit or end batch.
//
// sequence: a submit holds the sequencer through the accept, the slot
// resolve, an optional bind, four vertices and an optional flush; end
// batch holds it through the accept and the flush, begin batch through
// the accept alone.
// items are taken one at a time; items.ready is high while the sequencer
// is idle, even while a finished result still waits in the output register.
// a stalled receiver holds the sequencer at its next result.
// reset clears the batch counters and drops any pending result; the slot
// table needs no clearing since only entries below the fill count are read.
`default_nettype none

module quad_batch_vertex_expander_unit #(
  parameter int MAX_QUADS  = 2048,
  parameter int SLOT_COUNT = 31
) (
  input logic        clk,
  input logic        rst,
  qbve_in_if.sink    items,
  qbve_out_if.source results
);
  import qbve_pkg::*;

  qbve_cmd_t  cmd;
  qbve_stat_t st;

  qbve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_op    (items.operation),
    .in_ready (items.ready),
    .st       (st),
    .cmd      (cmd)
  );

  qbve_dpath #(
    .MAX_QUADS  (MAX_QUADS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .rect_x        (items.rect_x),
    .rect_y        (items.rect_y),
    .rect_width    (items.rect_width),
    .rect_height   (items.rect_height),
    .texture_id    (items.texture_id),
    .tex_left      (items.tex_left),
    .tex_top       (items.tex_top),
    .tex_span_x    (items.tex_span_x),
    .tex_span_y    (items.tex_span_y),
    .colour_in     (items.colour_in),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .result_kind   (results.result_kind),
    .vertex_x      (results.vertex_x),
    .vertex_y      (results.vertex_y),
    .tex_u         (results.tex_u),
    .tex_v         (results.tex_v),
    .colour_out    (results.colour_out),
    .slot_number   (results.slot_number),
    .bound_texture (results.bound_texture),
    .index_count   (results.index_count),
    .last          (results.last)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result written over a pending result");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !cmd.emit && !cmd.resolve)
    else $error("input taken while an item is in progress");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.kind == KIND_FLUSH) |-> (cmd.last && cmd.clr_cnt))
    else $error("flush without last or counter clear");

  a_quad_count: assert property (@(posedge clk) disable iff (rst)
    cmd.inc_quad |-> (cmd.emit && cmd.corner == CORNER_BL))
    else $error("quad counted outside its last vertex");

endmodule

`default_nettype wire
